[src/sparse_transpose_product_structure_assert.svh]
// Assertion macros shared by the RTL of the sparse product structure block.
// Depends on nothing; included by the top level only.
`ifndef SPARSE_TRANSPOSE_PRODUCT_STRUCTURE_ASSERT_SVH
`define SPARSE_TRANSPOSE_PRODUCT_STRUCTURE_ASSERT_SVH
// Implication checked in the same cycle.
`define STPS_ASSERT_IMP(lbl, ck, rn, pre, post) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (pre) |-> (post)) \
		else $error("stps assertion failed");
// Implication checked in the next cycle.
`define STPS_ASSERT_NEXT(lbl, ck, rn, pre, post) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (pre) |=> (post)) \
		else $error("stps assertion failed");
`endif

[src/stps_pkg.sv]
// Package of the sparse product structure block: sizes, codes and types.
// Depends on nothing; used by every other file of the block except the assertion header.
package stps_pkg;

	localparam int MaxAEntries = 1024;
	localparam int MaxBEntries = 1024;
	localparam int MaxDim = 256;
	localparam int MaxColTerms = 1024;
	localparam int QueueDepth = 2;

	localparam int DimW = $clog2(MaxDim);
	localparam int CfgW = 9;
	localparam int KeyW = 10;
	localparam int AAddrW = $clog2(MaxAEntries);
	localparam int ACntW = AAddrW + 1;
	localparam int BAddrW = $clog2(MaxBEntries);
	localparam int BCntW = BAddrW + 1;
	localparam int TermAddrW = $clog2(MaxColTerms);
	localparam int TermCntW = TermAddrW + 1;
	localparam int TotW = ACntW + BCntW - 1;
	localparam int MultW = 20;
	localparam int NzW = 17;
	localparam int QPtrW = $clog2(QueueDepth);
	localparam int QCntW = QPtrW + 1;

	localparam logic [MultW-1:0] MultSat = '1;
	localparam logic [NzW-1:0] NzSat = '1;

	typedef enum logic [1:0] {
		CMD_LOAD_A = 2'd0,
		CMD_LOAD_B = 2'd1,
		CMD_FETCH  = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	localparam logic [1:0] CFG_A_ROWS = 2'd0;
	localparam logic [1:0] CFG_A_COLS = 2'd1;
	localparam logic [1:0] CFG_B_COLS = 2'd2;

	typedef struct packed {
		logic [CfgW-1:0] a_rows;
		logic [CfgW-1:0] a_cols;
		logic [CfgW-1:0] b_cols;
	} cfg_t;

	typedef struct packed {
		cmd_t            cmd;
		logic            ok;
		logic [DimW-1:0] row;
		logic [DimW-1:0] col;
		logic [KeyW-1:0] key;
	} entry_t;

	typedef struct packed {
		logic [DimW-1:0] idx;
		logic [KeyW-1:0] key;
	} store_t;

	typedef struct packed {
		logic [ACntW-1:0] first;
		logic [ACntW-1:0] cnt;
	} a_tab_t;

	typedef struct packed {
		logic [BCntW-1:0] first;
		logic [BCntW-1:0] cnt;
	} b_tab_t;

	typedef struct packed {
		logic [DimW-1:0] prow;
		logic [KeyW-1:0] akey;
		logic [KeyW-1:0] bkey;
	} term_t;

	typedef struct packed {
		logic [DimW-1:0]  product_col;
		logic [DimW-1:0]  product_row;
		logic [KeyW-1:0]  a_key;
		logic [KeyW-1:0]  b_key;
		logic             starts_nonzero;
		logic             column_last;
		logic             done_res;
		logic [NzW-1:0]   nonzero_total;
		logic [MultW-1:0] multiply_total;
		logic             error;
	} res_t;

	function automatic logic [CfgW-1:0] eff_dim(input logic [CfgW-1:0] v);
		eff_dim = (v > CfgW'(MaxDim)) ? CfgW'(MaxDim) : v;
	endfunction

endpackage

[src/stps_if.sv]
// Channel interfaces of the sparse product structure block.
// Depends on stps_pkg for field widths.
interface stps_item_if;
	logic                      valid;
	logic                      ready;
	logic [1:0]                command;
	logic [stps_pkg::DimW-1:0] row_index;
	logic [stps_pkg::DimW-1:0] col_index;
	logic [stps_pkg::KeyW-1:0] entry_key;
	modport source(output valid, output command, output row_index, output col_index,
		output entry_key, input ready);
	modport sink(input valid, input command, input row_index, input col_index,
		input entry_key, output ready);
endinterface

interface stps_result_if;
	logic                       valid;
	logic                       ready;
	logic [stps_pkg::DimW-1:0]  product_col;
	logic [stps_pkg::DimW-1:0]  product_row;
	logic [stps_pkg::KeyW-1:0]  a_key;
	logic [stps_pkg::KeyW-1:0]  b_key;
	logic                       starts_nonzero;
	logic                       column_last;
	logic                       done_res;
	logic [stps_pkg::NzW-1:0]   nonzero_total;
	logic [stps_pkg::MultW-1:0] multiply_total;
	logic                       error;
	modport source(output valid, output product_col, output product_row, output a_key,
		output b_key, output starts_nonzero, output column_last, output done_res,
		output nonzero_total, output multiply_total, output error, input ready);
	modport sink(input valid, input product_col, input product_row, input a_key,
		input b_key, input starts_nonzero, input column_last, input done_res,
		input nonzero_total, input multiply_total, input error, output ready);
endinterface

interface stps_cfg_if;
	logic                      valid;
	logic                      ready;
	logic [1:0]                index;
	logic [stps_pkg::CfgW-1:0] data;
	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

[src/stps_front.sv]
// Front end: accepts input transactions and classifies them, checking load ranges.
// Depends on stps_pkg and stps_if.
module stps_front (
	stps_item_if.sink          req,
	input  stps_pkg::cfg_t     cfg,
	output logic               push_valid,
	input  logic               push_ready,
	output stps_pkg::entry_t   push_entry
);

	stps_pkg::cmd_t cmd;
	logic           ok;

	assign cmd = stps_pkg::cmd_t'(req.command);

	always_comb begin
		unique case (cmd)
			stps_pkg::CMD_LOAD_A: begin
				ok = ({1'b0, req.row_index} < cfg.a_rows) && ({1'b0, req.col_index} < cfg.a_cols);
			end
			stps_pkg::CMD_LOAD_B: begin
				ok = ({1'b0, req.row_index} < cfg.a_rows) && ({1'b0, req.col_index} < cfg.b_cols);
			end
			default: begin
				ok = 1'b0;
			end
		endcase
	end

	assign push_valid      = req.valid;
	assign req.ready       = push_ready;
	assign push_entry.cmd  = cmd;
	assign push_entry.ok   = ok;
	assign push_entry.row  = req.row_index;
	assign push_entry.col  = req.col_index;
	assign push_entry.key  = req.entry_key;

endmodule

[src/stps_queue.sv]
// Short queue of classified transactions between the front and back ends.
// Depends on stps_pkg.
module stps_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  stps_pkg::entry_t push_entry,
	output logic             pop_valid,
	input  logic             pop_ready,
	output stps_pkg::entry_t pop_entry
);

	stps_pkg::entry_t                  slots_q [stps_pkg::QueueDepth];
	logic [stps_pkg::QPtrW-1:0]        wr_ptr_q;
	logic [stps_pkg::QPtrW-1:0]        rd_ptr_q;
	logic [stps_pkg::QCntW-1:0]        count_q;
	logic                              push;
	logic                              pop;

	assign push_ready = count_q != stps_pkg::QCntW'(stps_pkg::QueueDepth);
	assign pop_valid  = count_q != '0;
	assign pop_entry  = slots_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == stps_pkg::QPtrW'(stps_pkg::QueueDepth - 1)) ? '0
					: wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == stps_pkg::QPtrW'(stps_pkg::QueueDepth - 1)) ? '0
					: rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[src/stps_back.sv]
// Back end: entry stores, start tables, column gather with counting sort, term output.
// Depends on stps_pkg.
module stps_back (
	input  logic             clk,
	input  logic             arst_n,
	input  stps_pkg::cfg_t   cfg,
	input  logic             pop_valid,
	output logic             pop_ready,
	input  stps_pkg::entry_t pop_entry,
	output logic             res_valid,
	input  logic             res_ready,
	output stps_pkg::res_t   res
);

	localparam int DimW = stps_pkg::DimW;
	localparam int ACntW = stps_pkg::ACntW;
	localparam int BCntW = stps_pkg::BCntW;
	localparam int AAddrW = stps_pkg::AAddrW;
	localparam int BAddrW = stps_pkg::BAddrW;
	localparam int TCntW = stps_pkg::TermCntW;
	localparam int TAddrW = stps_pkg::TermAddrW;
	localparam int TotW = stps_pkg::TotW;
	localparam int MultW = stps_pkg::MultW;
	localparam int NzW = stps_pkg::NzW;
	localparam int CfgW = stps_pkg::CfgW;
	localparam int Dim = stps_pkg::MaxDim;

	typedef enum logic [12:0] {
		S_IDLE = 13'b0000000000001,
		S_COL  = 13'b0000000000010,
		S_COLD = 13'b0000000000100,
		S_KCHK = 13'b0000000001000,
		S_KD   = 13'b0000000010000,
		S_JD   = 13'b0000000100000,
		S_LCHK = 13'b0000001000000,
		S_LD   = 13'b0000010000000,
		S_BD   = 13'b0000100000000,
		S_PRD  = 13'b0001000000000,
		S_PWR  = 13'b0010000000000,
		S_TRD  = 13'b0100000000000,
		S_TD   = 13'b1000000000000
	} state_t;

	typedef enum logic [1:0] {
		PASS_TOTAL = 2'd0,
		PASS_COUNT = 2'd1,
		PASS_PLACE = 2'd2
	} pass_t;

	stps_pkg::store_t a_store_mem [stps_pkg::MaxAEntries];
	stps_pkg::a_tab_t a_tab_mem [Dim];
	stps_pkg::store_t b_store_mem [stps_pkg::MaxBEntries];
	stps_pkg::b_tab_t b_tab_mem [Dim];
	logic [TCntW-1:0] bk_mem [Dim];
	stps_pkg::term_t  term_mem [stps_pkg::MaxColTerms];

	stps_pkg::store_t a_store_rd;
	stps_pkg::a_tab_t a_tab_rd;
	stps_pkg::store_t b_store_rd;
	stps_pkg::b_tab_t b_tab_rd;
	logic [TCntW-1:0] bk_rd;
	stps_pkg::term_t  term_rd;

	state_t            state_q;
	pass_t             pass_q;
	logic [ACntW-1:0]  a_loaded_q;
	logic              a_any_q;
	logic [DimW-1:0]   a_last_q;
	logic [ACntW-1:0]  a_first_q;
	logic [ACntW-1:0]  a_cnt_q;
	logic [Dim-1:0]    a_vld_q;
	logic [BCntW-1:0]  b_loaded_q;
	logic              b_any_q;
	logic [DimW-1:0]   b_last_q;
	logic [BCntW-1:0]  b_first_q;
	logic [BCntW-1:0]  b_cnt_q;
	logic [Dim-1:0]    b_vld_q;
	logic [Dim-1:0]    bk_vld_q;
	logic [CfgW-1:0]   cc_q;
	logic [TCntW-1:0]  ptr_q;
	logic [TCntW-1:0]  pend_q;
	logic [NzW-1:0]    nz_q;
	logic [MultW-1:0]  mult_q;
	logic              sticky_q;
	logic [BCntW-1:0]  k_q;
	logic [BCntW-1:0]  kbeg_q;
	logic [BCntW-1:0]  kend_q;
	logic [ACntW-1:0]  l_q;
	logic [ACntW-1:0]  lend_q;
	logic [DimW-1:0]   j_q;
	logic [stps_pkg::KeyW-1:0] bkey_q;
	logic [stps_pkg::KeyW-1:0] akey_q;
	logic [DimW-1:0]   prow_q;
	logic [TotW-1:0]   tot_q;
	logic [DimW-1:0]   r_q;
	logic [TCntW-1:0]  sum_q;
	logic [DimW-1:0]   prev_prow_q;
	logic              out_v_q;
	stps_pkg::res_t    out_q;

	logic              go;
	logic              a_ok;
	logic              a_same;
	logic              a_wr;
	stps_pkg::a_tab_t  a_tab_wd;
	logic              b_ok;
	logic              b_same;
	logic              b_wr;
	stps_pkg::b_tab_t  b_tab_wd;
	logic [DimW-1:0]   bk_ra;
	logic              bk_we;
	logic [DimW-1:0]   bk_wa;
	logic [TCntW-1:0]  bk_wd;
	logic [TCntW-1:0]  bv;
	logic              term_we;
	logic [ACntW-1:0]  a_row_cnt;
	logic [ACntW-1:0]  a_row_first;
	logic [BCntW-1:0]  b_col_cnt;
	logic [BCntW-1:0]  b_col_first;
	logic [MultW-1:0]  mult_room;
	logic [MultW-1:0]  mult_next;
	logic [TCntW-1:0]  ptr_inc;

	assign pop_ready = (state_q == S_IDLE) && !out_v_q;
	assign go        = pop_ready && pop_valid;
	assign res_valid = out_v_q;
	assign res       = out_q;

	assign a_same = a_any_q && (a_last_q == pop_entry.row);
	assign a_ok   = pop_entry.ok && (a_loaded_q < ACntW'(stps_pkg::MaxAEntries))
		&& (!a_any_q || (a_last_q <= pop_entry.row));
	assign a_wr   = go && (pop_entry.cmd == stps_pkg::CMD_LOAD_A) && a_ok;
	assign a_tab_wd.first = a_same ? a_first_q : a_loaded_q;
	assign a_tab_wd.cnt   = a_same ? a_cnt_q + 1'b1 : ACntW'(1);

	assign b_same = b_any_q && (b_last_q == pop_entry.col);
	assign b_ok   = pop_entry.ok && (b_loaded_q < BCntW'(stps_pkg::MaxBEntries))
		&& (!b_any_q || (b_last_q <= pop_entry.col));
	assign b_wr   = go && (pop_entry.cmd == stps_pkg::CMD_LOAD_B) && b_ok;
	assign b_tab_wd.first = b_same ? b_first_q : b_loaded_q;
	assign b_tab_wd.cnt   = b_same ? b_cnt_q + 1'b1 : BCntW'(1);

	assign bk_ra   = (state_q == S_PRD) ? r_q : a_store_rd.idx;
	assign bv      = (state_q == S_PWR) ? (bk_vld_q[r_q] ? bk_rd : '0)
		: (bk_vld_q[prow_q] ? bk_rd : '0);
	assign bk_we   = (state_q == S_BD) || (state_q == S_PWR);
	assign bk_wa   = (state_q == S_PWR) ? r_q : prow_q;
	assign bk_wd   = (state_q == S_PWR) ? sum_q : bv + 1'b1;
	assign term_we = (state_q == S_BD) && (pass_q == PASS_PLACE);

	assign a_row_cnt   = a_vld_q[j_q] ? a_tab_rd.cnt : '0;
	assign a_row_first = a_vld_q[j_q] ? a_tab_rd.first : '0;
	assign b_col_cnt   = b_vld_q[cc_q[DimW-1:0]] ? b_tab_rd.cnt : '0;
	assign b_col_first = b_vld_q[cc_q[DimW-1:0]] ? b_tab_rd.first : '0;
	assign mult_room = stps_pkg::MultSat - mult_q;
	assign mult_next = (tot_q >= TotW'(mult_room)) ? stps_pkg::MultSat
		: mult_q + tot_q[MultW-1:0];
	assign ptr_inc   = ptr_q + 1'b1;

	always_ff @(posedge clk) begin
		if (a_wr) begin
			a_store_mem[a_loaded_q[AAddrW-1:0]] <= '{idx: pop_entry.col, key: pop_entry.key};
			a_tab_mem[pop_entry.row] <= a_tab_wd;
		end
		a_store_rd <= a_store_mem[l_q[AAddrW-1:0]];
		a_tab_rd   <= a_tab_mem[b_store_rd.idx];
	end

	always_ff @(posedge clk) begin
		if (b_wr) begin
			b_store_mem[b_loaded_q[BAddrW-1:0]] <= '{idx: pop_entry.row, key: pop_entry.key};
			b_tab_mem[pop_entry.col] <= b_tab_wd;
		end
		b_store_rd <= b_store_mem[k_q[BAddrW-1:0]];
		b_tab_rd   <= b_tab_mem[cc_q[DimW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (bk_we) begin
			bk_mem[bk_wa] <= bk_wd;
		end
		bk_rd <= bk_mem[bk_ra];
	end

	always_ff @(posedge clk) begin
		if (term_we) begin
			term_mem[bv[TAddrW-1:0]] <= '{prow: prow_q, akey: akey_q, bkey: bkey_q};
		end
		term_rd <= term_mem[ptr_q[TAddrW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pass_q      <= PASS_TOTAL;
			a_loaded_q  <= '0;
			a_any_q     <= 1'b0;
			a_last_q    <= '0;
			a_first_q   <= '0;
			a_cnt_q     <= '0;
			a_vld_q     <= '0;
			b_loaded_q  <= '0;
			b_any_q     <= 1'b0;
			b_last_q    <= '0;
			b_first_q   <= '0;
			b_cnt_q     <= '0;
			b_vld_q     <= '0;
			bk_vld_q    <= '0;
			cc_q        <= '0;
			ptr_q       <= '0;
			pend_q      <= '0;
			nz_q        <= '0;
			mult_q      <= '0;
			sticky_q    <= 1'b0;
			k_q         <= '0;
			kbeg_q      <= '0;
			kend_q      <= '0;
			l_q         <= '0;
			lend_q      <= '0;
			j_q         <= '0;
			bkey_q      <= '0;
			akey_q      <= '0;
			prow_q      <= '0;
			tot_q       <= '0;
			r_q         <= '0;
			sum_q       <= '0;
			prev_prow_q <= '0;
			out_v_q     <= 1'b0;
			out_q       <= '0;
		end else begin
			if (out_v_q && res_ready) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (go) begin
						unique case (pop_entry.cmd)
							stps_pkg::CMD_LOAD_A: begin
								out_q   <= '0;
								out_v_q <= 1'b1;
								if (a_ok) begin
									a_loaded_q <= a_loaded_q + 1'b1;
									a_any_q    <= 1'b1;
									a_last_q   <= pop_entry.row;
									a_first_q  <= a_tab_wd.first;
									a_cnt_q    <= a_tab_wd.cnt;
									a_vld_q[pop_entry.row] <= 1'b1;
								end else begin
									out_q.error <= 1'b1;
									sticky_q    <= 1'b1;
								end
							end
							stps_pkg::CMD_LOAD_B: begin
								out_q   <= '0;
								out_v_q <= 1'b1;
								if (b_ok) begin
									b_loaded_q <= b_loaded_q + 1'b1;
									b_any_q    <= 1'b1;
									b_last_q   <= pop_entry.col;
									b_first_q  <= b_tab_wd.first;
									b_cnt_q    <= b_tab_wd.cnt;
									b_vld_q[pop_entry.col] <= 1'b1;
								end else begin
									out_q.error <= 1'b1;
									sticky_q    <= 1'b1;
								end
							end
							stps_pkg::CMD_FETCH: begin
								state_q <= (pend_q != '0) ? S_TRD : S_COL;
							end
							default: begin
								out_q   <= '0;
								out_v_q <= 1'b1;
							end
						endcase
					end
				end
				S_COL: begin
					if (cc_q >= stps_pkg::eff_dim(cfg.b_cols)) begin
						out_q                <= '0;
						out_q.done_res       <= 1'b1;
						out_q.nonzero_total  <= nz_q;
						out_q.multiply_total <= mult_q;
						out_q.error          <= sticky_q;
						out_v_q              <= 1'b1;
						state_q              <= S_IDLE;
					end else begin
						state_q <= S_COLD;
					end
				end
				S_COLD: begin
					k_q     <= b_col_first;
					kbeg_q  <= b_col_first;
					kend_q  <= b_col_first + b_col_cnt;
					tot_q   <= '0;
					pass_q  <= PASS_TOTAL;
					state_q <= S_KCHK;
				end
				S_KCHK: begin
					if (k_q != kend_q) begin
						state_q <= S_KD;
					end else begin
						unique case (pass_q)
							PASS_TOTAL: begin
								mult_q <= mult_next;
								if (tot_q > TotW'(stps_pkg::MaxColTerms)) begin
									out_q             <= '0;
									out_q.product_col <= cc_q[DimW-1:0];
									out_q.column_last <= 1'b1;
									out_q.error       <= 1'b1;
									out_v_q           <= 1'b1;
									sticky_q          <= 1'b1;
									cc_q              <= cc_q + 1'b1;
									state_q           <= S_IDLE;
								end else if (tot_q == '0) begin
									cc_q    <= cc_q + 1'b1;
									state_q <= S_COL;
								end else begin
									bk_vld_q <= '0;
									k_q      <= kbeg_q;
									pass_q   <= PASS_COUNT;
								end
							end
							PASS_COUNT: begin
								r_q     <= '0;
								sum_q   <= '0;
								state_q <= S_PRD;
							end
							default: begin
								pend_q  <= tot_q[TCntW-1:0];
								ptr_q   <= '0;
								state_q <= S_TRD;
							end
						endcase
					end
				end
				S_KD: begin
					j_q     <= b_store_rd.idx;
					bkey_q  <= b_store_rd.key;
					state_q <= S_JD;
				end
				S_JD: begin
					if (pass_q == PASS_TOTAL) begin
						tot_q   <= tot_q + TotW'(a_row_cnt);
						k_q     <= k_q + 1'b1;
						state_q <= S_KCHK;
					end else begin
						l_q     <= a_row_first;
						lend_q  <= a_row_first + a_row_cnt;
						state_q <= S_LCHK;
					end
				end
				S_LCHK: begin
					if (l_q == lend_q) begin
						k_q     <= k_q + 1'b1;
						state_q <= S_KCHK;
					end else begin
						state_q <= S_LD;
					end
				end
				S_LD: begin
					prow_q  <= a_store_rd.idx;
					akey_q  <= a_store_rd.key;
					state_q <= S_BD;
				end
				S_BD: begin
					bk_vld_q[prow_q] <= 1'b1;
					l_q              <= l_q + 1'b1;
					state_q          <= S_LCHK;
				end
				S_PRD: begin
					state_q <= S_PWR;
				end
				S_PWR: begin
					bk_vld_q[r_q] <= 1'b1;
					sum_q         <= sum_q + bv;
					if (r_q == DimW'(Dim - 1)) begin
						k_q     <= kbeg_q;
						pass_q  <= PASS_PLACE;
						state_q <= S_KCHK;
					end else begin
						r_q     <= r_q + 1'b1;
						state_q <= S_PRD;
					end
				end
				S_TRD: begin
					state_q <= S_TD;
				end
				S_TD: begin
					out_q             <= '0;
					out_q.product_col <= cc_q[DimW-1:0];
					out_q.product_row <= term_rd.prow;
					out_q.a_key       <= term_rd.akey;
					out_q.b_key       <= term_rd.bkey;
					out_v_q           <= 1'b1;
					prev_prow_q       <= term_rd.prow;
					if ((ptr_q == '0) || (prev_prow_q != term_rd.prow)) begin
						out_q.starts_nonzero <= 1'b1;
						if (nz_q != stps_pkg::NzSat) begin
							nz_q <= nz_q + 1'b1;
						end
					end
					if (ptr_inc >= pend_q) begin
						out_q.column_last <= 1'b1;
						pend_q            <= '0;
						ptr_q             <= '0;
						cc_q              <= cc_q + 1'b1;
					end else begin
						ptr_q <= ptr_inc;
					end
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

[src/sparse_transpose_product_structure.sv]
// Top level of the sparse product structure block: configuration registers and wiring.
// Depends on stps_pkg, stps_if, stps_front, stps_queue, stps_back and the assertion header.
//
// Finds the nonzero structure of A-transpose times B. Loads of A entries (rows in
// nondecreasing order) and B entries (columns in nondecreasing order) are checked and
// stored by the back end as they leave the queue. A fetch that returns an already sorted
// term reads it from the term store and registers it as the result. A fetch that opens a
// column of B runs its gather in the back end, which walks the column's B entries and
// their A rows one at a time; the gather includes a prefix sweep over the 256 row buckets.
// Columns with no terms are skipped without a result. One transaction is worked on at a
// time; the queue of two lets the input side go on accepting while a result waits to be
// taken.
`include "sparse_transpose_product_structure_assert.svh"

module sparse_transpose_product_structure (
	input  logic       clk,
	input  logic       arst_n,
	stps_item_if.sink  req,
	stps_result_if.source rsp,
	stps_cfg_if.sink   cfg
);

	stps_pkg::cfg_t   cfg_q;
	logic             push_valid;
	logic             push_ready;
	stps_pkg::entry_t push_entry;
	logic             pop_valid;
	logic             pop_ready;
	stps_pkg::entry_t pop_entry;
	stps_pkg::res_t   res;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.a_rows <= stps_pkg::CfgW'(stps_pkg::MaxDim);
			cfg_q.a_cols <= stps_pkg::CfgW'(stps_pkg::MaxDim);
			cfg_q.b_cols <= stps_pkg::CfgW'(stps_pkg::MaxDim);
		end else if (cfg.valid) begin
			unique case (cfg.index)
				stps_pkg::CFG_A_ROWS: cfg_q.a_rows <= cfg.data;
				stps_pkg::CFG_A_COLS: cfg_q.a_cols <= cfg.data;
				stps_pkg::CFG_B_COLS: cfg_q.b_cols <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	stps_front u_front (
		.req        (req),
		.cfg        (cfg_q),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry)
	);

	stps_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_entry  (pop_entry)
	);

	stps_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_entry (pop_entry),
		.res_valid (rsp.valid),
		.res_ready (rsp.ready),
		.res       (res)
	);

	assign rsp.product_col    = res.product_col;
	assign rsp.product_row    = res.product_row;
	assign rsp.a_key          = res.a_key;
	assign rsp.b_key          = res.b_key;
	assign rsp.starts_nonzero = res.starts_nonzero;
	assign rsp.column_last    = res.column_last;
	assign rsp.done_res       = res.done_res;
	assign rsp.nonzero_total  = res.nonzero_total;
	assign rsp.multiply_total = res.multiply_total;
	assign rsp.error          = res.error;

	`STPS_ASSERT_IMP(a_done_clean, clk, arst_n, rsp.valid && rsp.done_res, !rsp.starts_nonzero && !rsp.column_last)
	`STPS_ASSERT_IMP(a_start_ok, clk, arst_n, rsp.valid && rsp.starts_nonzero, !rsp.error && !rsp.done_res)
	`STPS_ASSERT_NEXT(a_hold_full, clk, arst_n, rsp.valid && !rsp.ready, rsp.valid && !pop_ready)

endmodule
